>>> rtl/ctr_pkg.sv
// ----------------------------------------------------------------------------
// Coverage trace recorder package
// Shared sizes, field positions, event kinds and the control/status bundles
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ctr_pkg;

    // Store depths
    localparam int INSN_DEPTH  = 1024;
    localparam int BLOCK_DEPTH = 64;
    localparam int INSN_AW     = $clog2(INSN_DEPTH);
    localparam int BLOCK_AW    = $clog2(BLOCK_DEPTH);
    localparam int INSN_CW     = $clog2(INSN_DEPTH + 1);
    localparam int BLOCK_CW    = $clog2(BLOCK_DEPTH + 1);

    // Field widths
    localparam int KIND_W     = 3;
    localparam int OFFSET_W   = 64;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 64;
    localparam int ICAP_W     = 11;
    localparam int BCAP_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Input transfer layout: tdata = {pad, index, offset}
    localparam int IN_OFF_LSB = 0;
    localparam int IN_IDX_LSB = OFFSET_W;
    localparam int IN_BITS    = OFFSET_W + INDEX_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

    // Output transfer layout, lowest field first
    localparam int OUT_HIT_LSB = 0;
    localparam int OUT_RD_LSB  = 1;
    localparam int OUT_IC_LSB  = OUT_RD_LSB + OFFSET_W;
    localparam int OUT_BC_LSB  = OUT_IC_LSB + COUNT_W;
    localparam int OUT_IS_LSB  = OUT_BC_LSB + COUNT_W;
    localparam int OUT_BS_LSB  = OUT_IS_LSB + ICAP_W;
    localparam int OUT_OV_LSB  = OUT_BS_LSB + BCAP_W;
    localparam int OUT_BITS    = OUT_OV_LSB + 1;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    // Event kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSN       = 3'd0,
        KIND_BLOCK      = 3'd1,
        KIND_QUERY      = 3'd2,
        KIND_READ_LOG   = 3'd3,
        KIND_READ_BLOCK = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INSN_CAP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_CAP = 1'b1;

    // Sequencer to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted item
        logic prep;     // issue reads at the item index, clear search state
        logic scan;     // step the block set search
        logic commit;   // update state and load the result register
    } ctr_cmd_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic need_scan;  // item searches the block set
        logic scan_done;  // search has covered every held entry
    } ctr_stat_t;

endpackage

>>> rtl/ctr_datapath.sv
// ----------------------------------------------------------------------------
// Coverage trace recorder datapath
// Holds the instruction log and block set memories, the fill counters, event
// totals, capacities, the block search unit and the result register.
// ----------------------------------------------------------------------------
module ctr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctr_pkg::ctr_cmd_t             cmd,
    output ctr_pkg::ctr_stat_t            stat,
    input  logic [ctr_pkg::KIND_W-1:0]    s_tuser,
    input  logic [ctr_pkg::IN_W-1:0]      s_tdata,
    input  logic                          cfg_valid,
    input  logic [ctr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ctr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [ctr_pkg::OUT_W-1:0]     m_tdata
);
    import ctr_pkg::*;

    // Item registers
    kind_t                 kind_reg;
    logic [OFFSET_W-1:0]   off_reg;
    logic [INDEX_W-1:0]    idx_reg;

    // Configuration
    logic [ICAP_W-1:0]     icap_reg;
    logic [BCAP_W-1:0]     bcap_reg;
    logic [INSN_CW-1:0]    icap_eff;
    logic [BLOCK_CW-1:0]   bcap_eff;

    // Persistent state
    logic [INSN_CW-1:0]    ifill_reg, ifill_next;
    logic [BLOCK_CW-1:0]   bfill_reg, bfill_next;
    logic [COUNT_W-1:0]    ievents_reg, ievents_next;
    logic [COUNT_W-1:0]    bevents_reg, bevents_next;
    logic                  drop_reg, drop_next;

    // Memories and their registered read data
    logic [OFFSET_W-1:0]   imem [INSN_DEPTH];
    logic [OFFSET_W-1:0]   bmem [BLOCK_DEPTH];
    logic [OFFSET_W-1:0]   ird_reg;
    logic [OFFSET_W-1:0]   brd_reg;
    logic [BLOCK_AW-1:0]   braddr;
    logic                  imem_we;
    logic                  bmem_we;

    // Search unit
    logic [BLOCK_CW-1:0]   ptr_reg;
    logic                  cmpv_reg;
    logic                  found_reg;
    logic                  issue;

    // Result
    logic                  hit_res;
    logic [OFFSET_W-1:0]   rd_res;
    logic [OUT_W-1:0]      out_next;
    logic [OUT_W-1:0]      out_reg;

    // Effective capacities clipped to the store depths
    assign icap_eff = (32'(icap_reg) > INSN_DEPTH) ? INSN_CW'(INSN_DEPTH) : INSN_CW'(icap_reg);
    assign bcap_eff = (32'(bcap_reg) > BLOCK_DEPTH) ? BLOCK_CW'(BLOCK_DEPTH)
                                                    : BLOCK_CW'(bcap_reg);

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind_t'(s_tuser);
            off_reg  <= s_tdata[IN_OFF_LSB +: OFFSET_W];
            idx_reg  <= s_tdata[IN_IDX_LSB +: INDEX_W];
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icap_reg <= ICAP_W'(1024);
            bcap_reg <= BCAP_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INSN_CAP:  icap_reg <= cfg_data[ICAP_W-1:0];
                CFG_BLOCK_CAP: bcap_reg <= cfg_data[BCAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Step the block search: one read per cycle, each entry compared in the cycle after its read
    assign issue  = cmd.scan && (ptr_reg < bfill_reg);
    assign braddr = cmd.scan ? BLOCK_AW'(ptr_reg) : BLOCK_AW'(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            cmpv_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.prep)
        begin
            ptr_reg   <= '0;
            cmpv_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (issue)
                ptr_reg <= ptr_reg + BLOCK_CW'(1);
            cmpv_reg <= issue;
            if (cmpv_reg && (brd_reg == off_reg))
                found_reg <= 1'b1;
        end
    end

    assign stat.need_scan = (kind_reg == KIND_BLOCK) || (kind_reg == KIND_QUERY);
    assign stat.scan_done = !issue && !cmpv_reg;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.commit && imem_we)
            imem[INSN_AW'(ifill_reg)] <= off_reg;
        ird_reg <= imem[INSN_AW'(idx_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && bmem_we)
            bmem[BLOCK_AW'(bfill_reg)] <= off_reg;
        brd_reg <= bmem[braddr];
    end

    // Work out the state update and the result for the item
    always_comb
    begin
        ifill_next   = ifill_reg;
        bfill_next   = bfill_reg;
        ievents_next = ievents_reg;
        bevents_next = bevents_reg;
        drop_next    = drop_reg;
        imem_we      = 1'b0;
        bmem_we      = 1'b0;
        hit_res      = 1'b0;
        rd_res       = '0;
        case (kind_reg)
            KIND_INSN:
            begin
                ievents_next = ievents_reg + COUNT_W'(1);
                if (icap_eff != '0)
                begin
                    if (ifill_reg < icap_eff)
                    begin
                        imem_we    = 1'b1;
                        ifill_next = ifill_reg + INSN_CW'(1);
                    end
                    else
                        drop_next = 1'b1;
                end
            end
            KIND_BLOCK:
            begin
                bevents_next = bevents_reg + COUNT_W'(1);
                if (bcap_eff != '0)
                begin
                    if (found_reg)
                        hit_res = 1'b1;
                    else if (bfill_reg < bcap_eff)
                    begin
                        bmem_we    = 1'b1;
                        bfill_next = bfill_reg + BLOCK_CW'(1);
                    end
                    else
                        drop_next = 1'b1;
                end
            end
            KIND_QUERY:
                hit_res = (bcap_eff != '0) && found_reg;
            KIND_READ_LOG:
                if (32'(idx_reg) < 32'(ifill_reg))
                    rd_res = ird_reg;
            KIND_READ_BLOCK:
                if (32'(idx_reg) < 32'(bfill_reg))
                    rd_res = brd_reg;
            default: ;
        endcase
    end

    // Commit state and load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ifill_reg   <= '0;
            bfill_reg   <= '0;
            ievents_reg <= '0;
            bevents_reg <= '0;
            drop_reg    <= 1'b0;
        end
        else if (cmd.commit)
        begin
            ifill_reg   <= ifill_next;
            bfill_reg   <= bfill_next;
            ievents_reg <= ievents_next;
            bevents_reg <= bevents_next;
            drop_reg    <= drop_next;
        end
    end

    // Pack the result fields, lowest first
    always_comb
    begin
        out_next                         = '0;
        out_next[OUT_HIT_LSB]            = hit_res;
        out_next[OUT_RD_LSB +: OFFSET_W] = rd_res;
        out_next[OUT_IC_LSB +: COUNT_W]  = ievents_next;
        out_next[OUT_BC_LSB +: COUNT_W]  = bevents_next;
        out_next[OUT_IS_LSB +: ICAP_W]   = ICAP_W'(ifill_next);
        out_next[OUT_BS_LSB +: BCAP_W]   = BCAP_W'(bfill_next);
        out_next[OUT_OV_LSB]             = drop_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_reg <= out_next;
    end

    assign m_tdata = out_reg;

endmodule

>>> rtl/ctr_ctrl.sv
// ----------------------------------------------------------------------------
// Coverage trace recorder sequencer
// Steps each item through capture, read issue, block search (block events and
// queries only) and commit, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module ctr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ctr_pkg::ctr_cmd_t  cmd,
    input  ctr_pkg::ctr_stat_t stat
);
    import ctr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // Result slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.prep   = (state_reg == ST_PREP);
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_COMMIT) && out_free;

    // Advance the sequence and hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise the flag at commit, drop it once the result is taken
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_tvalid)
                        state_reg <= ST_PREP;
                ST_PREP:
                    state_reg <= stat.need_scan ? ST_SCAN : ST_COMMIT;
                ST_SCAN:
                    if (stat.scan_done)
                        state_reg <= ST_COMMIT;
                ST_COMMIT:
                    if (out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/coverage_trace_recorder.sv
// ----------------------------------------------------------------------------
// Coverage trace recorder
// Logs instruction offsets, keeps a set of distinct block offsets, counts
// events and answers coverage and read-back queries, one result per item.
//
//   channel  | signals                       | content
//   ---------+-------------------------------+---------------------------------
//   s_*      | tvalid tready tdata tuser     | event or query item
//   m_*      | tvalid tready tdata           | one result per item
//   cfg_*    | cfg_valid cfg_ready cfg_index | capacity register writes
//            | cfg_data                      |
//
// The sequencer captures an item, issues reads and commits the result to the
// output register, and takes the next item from the cycle the result shows.
// Block events and coverage queries add the block set search before commit:
// one entry read per cycle from the single read port of the set memory plus
// a final compare. One item is in work at a time; a finished result waits in
// the output register while the next item is taken. A stalled m_tready holds
// the result and stops the commit of the following item. Reset clears all
// counters, fills and flags at once; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module coverage_trace_recorder (
    input  logic                           clk,
    input  logic                           rst_n,
    // Item: tuser = kind
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctr_pkg::KIND_W-1:0]     s_tuser,
    // Item: tdata = offset[63:0], index[73:64], zero pad
    input  logic [ctr_pkg::IN_W-1:0]       s_tdata,
    // Result: tdata = hit[0], read_value[64:1], insn_count[128:65],
    // block_count[192:129], insn_stored[203:193], blocks_stored[210:204],
    // overflowed[211], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ctr_pkg::OUT_W-1:0]      m_tdata,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ctr_pkg::*;

    ctr_cmd_t  cmd;
    ctr_stat_t stat;

    // Capacity writes always land at once
    assign cfg_ready = 1'b1;

    ctr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ctr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/ctr_checker.sv
// ----------------------------------------------------------------------------
// Coverage trace recorder port checker
// Watches the top level ports for result handling, item pacing and store
// fill bounds.
// ----------------------------------------------------------------------------
module ctr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ctr_pkg::OUT_W-1:0]  m_tdata
);
    import ctr_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in work: no transfer in the cycle after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous item still in work");

    // A new result only appears out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in work");

    // Fills stay within the store depths
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[OUT_IS_LSB +: ICAP_W]) <= INSN_DEPTH)
                  && (32'(m_tdata[OUT_BS_LSB +: BCAP_W]) <= BLOCK_DEPTH))
        else $error("store fill beyond depth");

endmodule

bind coverage_trace_recorder ctr_checker u_ctr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
